>>> design/tis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tis_pkg
// Shared types and constants of the table interpolating sampler.
// ----------------------------------------------------------------------------
package tis_pkg;

	localparam int TABLE_DEPTH_DEF   = 1024;
	localparam int POS_FRAC_BITS_DEF = 16;

	localparam int LEN_W       = 11;
	localparam int INDEX_W     = 10;
	localparam int VALUE_W     = 16;
	localparam int POS_W       = 32;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 11;

	// cubic weight format and accumulator
	localparam int WEIGHT_BITS = 15;
	localparam int CUBIC_SHIFT = 3 * WEIGHT_BITS + 1;
	localparam int H_W         = 49;
	localparam int H_SPLIT     = 24;
	localparam int ACC_W       = 64;
	localparam int MUL_A_W     = H_W - H_SPLIT;
	localparam int MUL_B_W     = VALUE_W + 1;
	localparam int MUL_P_W     = MUL_A_W + MUL_B_W;

	localparam int SAMPLE_MAX = 32767;
	localparam int SAMPLE_MIN = -32768;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_TABLE_LENGTH  = 2'd0,
		CFG_INTERPOLATION = 2'd1,
		CFG_EDGE_MODE     = 2'd2
	} cfg_index_t;

	localparam logic OP_WRITE      = 1'b0;
	localparam logic OP_QUERY      = 1'b1;
	localparam logic INTERP_LINEAR = 1'b0;
	localparam logic INTERP_CUBIC  = 1'b1;
	localparam logic EDGE_CLAMP    = 1'b0;
	localparam logic EDGE_WRAP     = 1'b1;

	typedef struct packed {
		logic [LEN_W-1:0] table_length;
		logic             interpolation;
		logic             edge_mode;
	} cfg_t;

	typedef struct packed {
		logic                      query;
		logic                      wr_ok;
		logic [INDEX_W-1:0]        entry_index;
		logic signed [VALUE_W-1:0] entry_value;
		logic signed [POS_W-1:0]   position;
		logic                      final_query;
	} item_t;

endpackage

>>> design/tis_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tis_front
// Command intake: registers a beat, tags it as write or query, feeds the queue.
// ----------------------------------------------------------------------------
module tis_front #(
	parameter int TABLE_DEPTH = tis_pkg::TABLE_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               operation,
	input  logic [tis_pkg::INDEX_W-1:0]        entry_index,
	input  logic signed [tis_pkg::VALUE_W-1:0] entry_value,
	input  logic signed [tis_pkg::POS_W-1:0]   position,
	input  logic                               final_query,
	output logic                               push_valid,
	output tis_pkg::item_t                     push_item,
	input  logic                               q_full
);

	logic           valid_s1;
	tis_pkg::item_t item_s1;
	logic           take;

	assign busy       = valid_s1 & q_full;
	assign take       = start & ~busy;
	assign push_valid = valid_s1 & ~q_full;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (!q_full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.query       <= (operation == tis_pkg::OP_QUERY);
			// writes past the table depth are dropped
			item_s1.wr_ok       <= (32'(entry_index) < TABLE_DEPTH);
			item_s1.entry_index <= entry_index;
			item_s1.entry_value <= entry_value;
			item_s1.position    <= position;
			item_s1.final_query <= final_query;
		end
	end

endmodule

>>> design/tis_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tis_queue
// Short FIFO of tagged items between intake and engine.
// ----------------------------------------------------------------------------
module tis_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tis_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           valid,
	output tis_pkg::item_t item
);

	localparam int QD  = tis_pkg::QUEUE_DEPTH;
	localparam int PW  = (QD > 1) ? $clog2(QD) : 1;
	localparam int CNW = $clog2(QD + 1);

	tis_pkg::item_t    slots_q [QD];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CNW-1:0]    count_q;

	assign full  = (count_q == CNW'(QD));
	assign valid = (count_q != '0);
	assign item  = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QD - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QD - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

>>> design/tis_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tis_back
// Engine: table memory, edge handling, neighbor fetch, shared MAC, rounding.
// ----------------------------------------------------------------------------
module tis_back #(
	parameter int TABLE_DEPTH            = tis_pkg::TABLE_DEPTH_DEF,
	parameter int POSITION_FRACTION_BITS = tis_pkg::POS_FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  tis_pkg::cfg_t                      cfg,
	input  logic                               q_valid,
	input  tis_pkg::item_t                     q_item,
	output logic                               pop,
	output logic                               done,
	output logic signed [tis_pkg::VALUE_W-1:0] sample_value,
	output logic                               saturated,
	output logic                               last_of_batch
);

	localparam int F     = POSITION_FRACTION_BITS;
	localparam int AW    = $clog2(TABLE_DEPTH);
	localparam int LW    = tis_pkg::LEN_W;
	localparam int VW    = tis_pkg::VALUE_W;
	localparam int WB    = tis_pkg::WEIGHT_BITS;
	localparam int HW    = tis_pkg::H_W;
	localparam int HS    = tis_pkg::H_SPLIT;
	localparam int AC    = tis_pkg::ACC_W;
	localparam int MA    = tis_pkg::MUL_A_W;
	localparam int MB    = tis_pkg::MUL_B_W;
	localparam int MP    = tis_pkg::MUL_P_W;
	localparam int IW    = tis_pkg::POS_W - F;
	localparam int CW    = ((IW > LW) ? IW : LW) + 2;
	localparam int MCW   = $clog2(IW + 1);
	localparam int LIN_STEPS   = 1;
	localparam int CUBIC_STEPS = 8;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DISPATCH, ST_MOD, ST_FIX, ST_NBR, ST_READ, ST_MAC, ST_ROUND, ST_OUT
	} state_t;

	state_t                 state_q;
	tis_pkg::item_t         item_q;
	logic [LW-1:0]          idx_q, i1_q, i3_q, i4_q, rem_q;
	logic [F-1:0]           frac_q;
	logic                   neg_q;
	logic [IW-1:0]          mag_q;
	logic [MCW-1:0]         mod_cnt_q;
	logic [2:0]             rd_cnt_q;
	logic signed [VW-1:0]   p1_q, p2_q, p3_q, p4_q, rdata_q;
	logic [2*WB-1:0]        w2_q;
	logic [3*WB-1:0]        w3_q;
	logic signed [HW-1:0]   h1_q, h2_q, h3_q, h4_q;
	logic [3:0]             mac_cnt_q;
	logic signed [MP-1:0]   prod_q;
	logic                   prod_hi_q, prod_v_q;
	logic signed [AC-1:0]   acc_q, val_q;

	logic [VW-1:0] mem [TABLE_DEPTH];

	// ---- effective length ----
	logic [LW-1:0] len, maxi;
	assign len  = (32'(cfg.table_length) > TABLE_DEPTH) ? LW'(TABLE_DEPTH)
	                                                   : cfg.table_length;
	assign maxi = len - 1'b1;

	// ---- position split ----
	logic [IW-1:0]        ip;
	logic [F-1:0]         fr;
	logic signed [CW-1:0] ip_ext, maxi_ext;
	assign ip       = item_q.position[tis_pkg::POS_W-1:F];
	assign fr       = item_q.position[F-1:0];
	assign ip_ext   = $signed({{(CW-IW){ip[IW-1]}}, ip});
	assign maxi_ext = $signed({{(CW-LW){1'b0}}, maxi});

	// ---- modulo step: restoring, one quotient bit per cycle ----
	logic [LW:0] mod_t;
	logic [LW-1:0] rem_next;
	assign mod_t    = {rem_q, mag_q[IW-1]};
	assign rem_next = (mod_t >= {1'b0, len}) ? LW'(mod_t - {1'b0, len}) : mod_t[LW-1:0];

	// ---- neighbors ----
	logic [LW:0]   idx1, idx2, t4a, t4b;
	logic [LW-1:0] n1, n3, n4;
	assign idx1 = {1'b0, idx_q} + 1'b1;
	assign idx2 = {1'b0, idx_q} + 2'd2;
	assign t4a  = (idx2 >= {1'b0, len}) ? idx2 - {1'b0, len} : idx2;
	// a one-entry table needs the second fold
	assign t4b  = (t4a >= {1'b0, len}) ? t4a - {1'b0, len} : t4a;

	always_comb begin
		if (cfg.edge_mode == tis_pkg::EDGE_WRAP) begin
			n1 = (idx_q != '0) ? idx_q - 1'b1 : maxi;
			n3 = (idx1 == {1'b0, len}) ? '0 : idx1[LW-1:0];
			n4 = t4b[LW-1:0];
		end else begin
			n1 = (idx_q != '0) ? idx_q - 1'b1 : '0;
			n3 = (idx_q < maxi) ? idx1[LW-1:0] : maxi;
			n4 = (idx2 <= {1'b0, maxi}) ? idx2[LW-1:0] : maxi;
		end
	end

	// ---- memory ports ----
	logic          mem_we;
	logic [AW-1:0] waddr, raddr;
	assign mem_we = (state_q == ST_DISPATCH) && !item_q.query && item_q.wr_ok;
	assign waddr  = AW'(item_q.entry_index);

	always_comb begin
		case (rd_cnt_q[1:0])
			2'd0:    raddr = AW'(i1_q);
			2'd1:    raddr = AW'(idx_q);
			2'd2:    raddr = AW'(i3_q);
			default: raddr = AW'(i4_q);
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= item_q.entry_value;
		end
		rdata_q <= $signed(mem[raddr]);
	end

	// ---- cubic weights ----
	logic [F+WB-1:0]      wfull;
	logic [WB-1:0]        w;
	logic signed [HW-1:0] w2s, w3e, w30, h2n;
	assign wfull = {frac_q, {WB{1'b0}}} >> F;
	assign w     = wfull[WB-1:0];
	assign w2s   = $signed(HW'({w2_q, {WB{1'b0}}}));
	assign w3e   = $signed(HW'(w3_q));
	assign w30   = $signed(HW'({w, {(2*WB){1'b0}}}));
	assign h2n   = (w2s <<< 2) + (w2s <<< 1) - (w3e <<< 2);

	// ---- MAC operand select ----
	logic signed [HW-1:0] h_sel;
	logic signed [MB-1:0] d_sel, b_op;
	logic signed [MA-1:0] a_op;
	logic [3:0]           n_steps;
	logic signed [AC-1:0] addend;

	always_comb begin
		case (mac_cnt_q[2:1])
			2'd0: begin
				h_sel = h1_q;
				d_sel = MB'(p2_q);
			end
			2'd1: begin
				h_sel = h2_q;
				d_sel = MB'(p3_q);
			end
			2'd2: begin
				h_sel = h3_q;
				d_sel = MB'(p3_q) - MB'(p1_q);
			end
			default: begin
				h_sel = h4_q;
				d_sel = MB'(p4_q) - MB'(p2_q);
			end
		endcase
		if (cfg.interpolation == tis_pkg::INTERP_CUBIC) begin
			a_op    = mac_cnt_q[0] ? h_sel[HW-1:HS] : $signed({1'b0, h_sel[HS-1:0]});
			b_op    = d_sel;
			n_steps = 4'(CUBIC_STEPS);
		end else begin
			a_op    = $signed(MA'(frac_q));
			b_op    = MB'(p3_q) - MB'(p2_q);
			n_steps = 4'(LIN_STEPS);
		end
	end

	assign addend = prod_hi_q ? (AC'(prod_q) <<< HS) : AC'(prod_q);
	assign pop    = (state_q == ST_IDLE) && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			done          <= 1'b0;
			sample_value  <= '0;
			saturated     <= 1'b0;
			last_of_batch <= 1'b0;
			prod_v_q      <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						item_q  <= q_item;
						state_q <= ST_DISPATCH;
					end
				end
				ST_DISPATCH: begin
					if (!item_q.query) begin
						state_q <= ST_IDLE;
					end else if (len == '0) begin
						val_q   <= '0;
						state_q <= ST_OUT;
					end else if (cfg.edge_mode == tis_pkg::EDGE_WRAP) begin
						neg_q     <= ip[IW-1];
						mag_q     <= ip[IW-1] ? (~ip + 1'b1) : ip;
						frac_q    <= fr;
						rem_q     <= '0;
						mod_cnt_q <= '0;
						state_q   <= ST_MOD;
					end else begin
						if (ip[IW-1]) begin
							idx_q  <= '0;
							frac_q <= '0;
						end else if (ip_ext > maxi_ext || (ip_ext == maxi_ext && fr != '0)) begin
							idx_q  <= maxi;
							frac_q <= '0;
						end else begin
							idx_q  <= LW'(ip);
							frac_q <= fr;
						end
						state_q <= ST_NBR;
					end
				end
				ST_MOD: begin
					rem_q     <= rem_next;
					mag_q     <= mag_q << 1;
					mod_cnt_q <= mod_cnt_q + 1'b1;
					if (mod_cnt_q == MCW'(IW - 1)) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: begin
					// floor semantics for negative integer parts
					idx_q   <= (neg_q && rem_q != '0) ? len - rem_q : rem_q;
					state_q <= ST_NBR;
				end
				ST_NBR: begin
					i1_q     <= n1;
					i3_q     <= n3;
					i4_q     <= n4;
					rd_cnt_q <= '0;
					state_q  <= ST_READ;
				end
				ST_READ: begin
					rd_cnt_q <= rd_cnt_q + 1'b1;
					case (rd_cnt_q)
						3'd0: begin
							w2_q <= w * w;
						end
						3'd1: begin
							w3_q <= w2_q * w;
							p1_q <= rdata_q;
						end
						3'd2: begin
							h2_q <= h2n;
							h1_q <= (HW'(1) <<< tis_pkg::CUBIC_SHIFT) - h2n;
							h3_q <= w3e - (w2s <<< 1) + w30;
							h4_q <= w3e - w2s;
							p2_q <= rdata_q;
						end
						3'd3: begin
							p3_q <= rdata_q;
						end
						default: begin
							p4_q      <= rdata_q;
							mac_cnt_q <= '0;
							prod_v_q  <= 1'b0;
							acc_q     <= (cfg.interpolation == tis_pkg::INTERP_CUBIC) ? '0
							             : (AC'(p2_q) <<< F);
							state_q   <= ST_MAC;
						end
					endcase
				end
				ST_MAC: begin
					mac_cnt_q <= mac_cnt_q + 1'b1;
					if (prod_v_q) begin
						acc_q <= acc_q + addend;
					end
					if (mac_cnt_q < n_steps) begin
						prod_q    <= a_op * b_op;
						prod_hi_q <= (cfg.interpolation == tis_pkg::INTERP_CUBIC) & mac_cnt_q[0];
						prod_v_q  <= 1'b1;
					end else begin
						prod_v_q <= 1'b0;
					end
					if (mac_cnt_q == n_steps) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					if (cfg.interpolation == tis_pkg::INTERP_CUBIC) begin
						val_q <= (acc_q + (AC'(1) <<< (tis_pkg::CUBIC_SHIFT - 1)))
						         >>> tis_pkg::CUBIC_SHIFT;
					end else begin
						val_q <= (acc_q + (AC'(1) <<< (F - 1))) >>> F;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (val_q > AC'(tis_pkg::SAMPLE_MAX)) begin
						sample_value <= VW'(tis_pkg::SAMPLE_MAX);
						saturated    <= 1'b1;
					end else if (val_q < AC'(tis_pkg::SAMPLE_MIN)) begin
						sample_value <= VW'(tis_pkg::SAMPLE_MIN);
						saturated    <= 1'b1;
					end else begin
						sample_value <= val_q[VW-1:0];
						saturated    <= 1'b0;
					end
					last_of_batch <= item_q.final_query;
					done          <= 1'b1;
					state_q       <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_pop_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q == ST_DISPATCH)
		else $error("popped item not dispatched");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_NBR |-> idx_q < len)
		else $error("base index outside table");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MOD |-> rem_q < len)
		else $error("modulo remainder out of range");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && saturated) |-> (sample_value == VW'(tis_pkg::SAMPLE_MAX) ||
		                         sample_value == VW'(tis_pkg::SAMPLE_MIN)))
		else $error("saturation flag without clipped value");

endmodule

>>> design/table_interpolating_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// table_interpolating_sampler
// Sample table with linear or Catmull-Rom cubic lookup, clamp or wrap edges.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  command   start / busy         operation, entry_index, entry_value,
//                                 position, final_query
//  result    done (1-cycle pulse) sample_value, saturated, last_of_batch
//  config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  Write beat: through intake, queue and engine.
//  Query: four reads on the single read port, then the shared 25x17 MAC
//  (eight passes for cubic); wrap adds the bit-serial modulo by the table
//  length.
//  Reset clears control only; table contents are undefined until written.
//  busy rises only when the intake stage and the two-entry queue are full;
//  results cannot be stalled.
// ----------------------------------------------------------------------------
module table_interpolating_sampler #(
	parameter int TABLE_DEPTH            = tis_pkg::TABLE_DEPTH_DEF,
	parameter int POSITION_FRACTION_BITS = tis_pkg::POS_FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic                                  operation,
	input  logic [tis_pkg::INDEX_W-1:0]           entry_index,
	input  logic signed [tis_pkg::VALUE_W-1:0]    entry_value,
	input  logic signed [tis_pkg::POS_W-1:0]      position,
	input  logic                                  final_query,
	output logic                                  done,
	output logic signed [tis_pkg::VALUE_W-1:0]    sample_value,
	output logic                                  saturated,
	output logic                                  last_of_batch,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [tis_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [tis_pkg::CFG_DATA_W-1:0]        cfg_data
);

	tis_pkg::cfg_t  cfg_q;
	tis_pkg::item_t push_item, q_item;
	logic           push_valid, q_full, q_valid, pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (tis_pkg::cfg_index_t'(cfg_index))
				tis_pkg::CFG_TABLE_LENGTH:  cfg_q.table_length  <= cfg_data;
				tis_pkg::CFG_INTERPOLATION: cfg_q.interpolation <= cfg_data[0];
				tis_pkg::CFG_EDGE_MODE:     cfg_q.edge_mode     <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	tis_front #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.entry_index(entry_index),
		.entry_value(entry_value),
		.position   (position),
		.final_query(final_query),
		.push_valid (push_valid),
		.push_item  (push_item),
		.q_full     (q_full)
	);

	tis_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push_valid),
		.push_item(push_item),
		.full     (q_full),
		.pop      (pop),
		.valid    (q_valid),
		.item     (q_item)
	);

	tis_back #(
		.TABLE_DEPTH           (TABLE_DEPTH),
		.POSITION_FRACTION_BITS(POSITION_FRACTION_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.pop          (pop),
		.done         (done),
		.sample_value (sample_value),
		.saturated    (saturated),
		.last_of_batch(last_of_batch)
	);

endmodule

>>> bench/tb_table_interpolating_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_table_interpolating_sampler
// Self-checking bench for the table interpolating sampler: loads the table,
// sweeps length, interpolation and edge settings, and compares every sample
// beat against a local linear / Catmull-Rom predictor.
// ----------------------------------------------------------------------------
module tb_table_interpolating_sampler;

	localparam int  DEPTH    = 1024;
	localparam int  FB       = 16;
	localparam int  WD_LIMIT = 20000;

	typedef struct {
		logic                               op;
		logic [tis_pkg::INDEX_W-1:0]        idx;
		logic signed [tis_pkg::VALUE_W-1:0] val;
		logic signed [tis_pkg::POS_W-1:0]   pos;
		logic                               fin;
	} cmd_t;

	typedef struct {
		logic signed [tis_pkg::VALUE_W-1:0] value;
		logic                               sat;
		logic                               last;
	} sample_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic operation = 1'b0;
	logic [tis_pkg::INDEX_W-1:0] entry_index = '0;
	logic signed [tis_pkg::VALUE_W-1:0] entry_value = '0;
	logic signed [tis_pkg::POS_W-1:0] position = '0;
	logic final_query = 1'b0;
	logic done;
	logic signed [tis_pkg::VALUE_W-1:0] sample_value;
	logic saturated;
	logic last_of_batch;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [tis_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [tis_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	cmd_t    pending_cmds[$];
	sample_t expected_samples[$];
	logic signed [tis_pkg::VALUE_W-1:0] shadow_table[DEPTH];
	logic [tis_pkg::LEN_W-1:0] cur_len = '0;
	logic cur_interp = tis_pkg::INTERP_LINEAR;
	logic cur_edge = tis_pkg::EDGE_CLAMP;
	int  mismatches = 0;
	int  quiet_cycles = 0;
	bit  no_gaps = 1'b0;

	table_interpolating_sampler dut (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic longint round_down(longint v, int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic sample_t interpolate(logic signed [tis_pkg::POS_W-1:0] pos_in, logic fin);
		sample_t r;
		longint one, p, fr, span, v, w, w2q, w3, h1, h2, h3h, h4h, q1, p1, p2, p3, p4;
		int len, maxi, idx, i1, i3, i4;
		one = longint'(1) <<< FB;
		q1 = longint'(1) <<< tis_pkg::WEIGHT_BITS;
		r.value = '0;
		r.sat = 1'b0;
		r.last = fin;
		len = (cur_len > DEPTH) ? DEPTH : int'(cur_len);
		if (len == 0)
			return r;
		maxi = len - 1;
		p = longint'(pos_in);
		if (cur_edge == tis_pkg::EDGE_WRAP) begin
			span = longint'(len) * one;
			p = p % span;
			if (p < 0)
				p = p + span;
			idx = int'(p >>> FB);
			fr = p & (one - 1);
			i1 = (idx > 0) ? idx - 1 : maxi;
			i3 = (idx + 1) % len;
			i4 = (idx + 2) % len;
		end else begin
			if (p < 0)
				p = 0;
			if (p > longint'(maxi) * one)
				p = longint'(maxi) * one;
			idx = int'(p >>> FB);
			fr = p & (one - 1);
			i1 = (idx > 0) ? idx - 1 : 0;
			i3 = (idx < maxi) ? idx + 1 : maxi;
			i4 = (idx + 2 <= maxi) ? idx + 2 : maxi;
		end
		if (cur_interp == tis_pkg::INTERP_LINEAR) begin
			p1 = shadow_table[idx];
			p2 = shadow_table[i3];
			v = round_down(p1 * one + fr * (p2 - p1), FB);
		end else begin
			p1 = shadow_table[i1];
			p2 = shadow_table[idx];
			p3 = shadow_table[i3];
			p4 = shadow_table[i4];
			w = fr >>> (FB - tis_pkg::WEIGHT_BITS);
			w2q = w * w * q1;
			w3 = w * w * w;
			h2 = 2 * (3 * w2q - 2 * w3);
			h1 = (longint'(1) <<< tis_pkg::CUBIC_SHIFT) - h2;
			h3h = w3 - 2 * w2q + w * q1 * q1;
			h4h = w3 - w2q;
			v = round_down(h1 * p2 + h2 * p3 + h3h * (p3 - p1) + h4h * (p4 - p2),
				tis_pkg::CUBIC_SHIFT);
		end
		if (v > tis_pkg::SAMPLE_MAX) begin
			v = tis_pkg::SAMPLE_MAX;
			r.sat = 1'b1;
		end else if (v < tis_pkg::SAMPLE_MIN) begin
			v = tis_pkg::SAMPLE_MIN;
			r.sat = 1'b1;
		end
		r.value = v[tis_pkg::VALUE_W-1:0];
		return r;
	endfunction

	// command driver: one beat per start && !busy edge
	always @(posedge clk) begin
		cmd_t c;
		logic take;
		take = start && !busy;
		if (take) begin
			c = pending_cmds.pop_front();
			if (c.op == tis_pkg::OP_WRITE)
				shadow_table[c.idx] = c.val;
			else
				expected_samples.push_back(interpolate(c.pos, c.fin));
		end
		if (start && !take) begin
			// hold the beat while busy
		end else if (arst_n && pending_cmds.size() > 0
				&& (no_gaps || $urandom_range(99) >= 10)) begin
			c = pending_cmds[0];
			start <= 1'b1;
			operation <= c.op;
			entry_index <= c.idx;
			entry_value <= c.val;
			position <= c.pos;
			final_query <= c.fin;
		end else begin
			start <= 1'b0;
		end
	end

	task automatic report(string what, longint got, longint want);
		$display("error at %0t: %s got %0d want %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		sample_t e;
		if (done) begin
			if (expected_samples.size() == 0) begin
				report("unexpected sample beat", sample_value, 0);
			end else begin
				e = expected_samples.pop_front();
				if (sample_value !== e.value)
					report("sample_value", sample_value, e.value);
				if (saturated !== e.sat)
					report("saturated", saturated, e.sat);
				if (last_of_batch !== e.last)
					report("last_of_batch", last_of_batch, e.last);
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WD_LIMIT) begin
			$display("table_interpolating_sampler: mismatch");
			$finish;
		end
	end

	task automatic push_write(int i, int v);
		cmd_t c;
		c.op = tis_pkg::OP_WRITE;
		c.idx = i[tis_pkg::INDEX_W-1:0];
		c.val = v[tis_pkg::VALUE_W-1:0];
		c.pos = $urandom;
		c.fin = 1'($urandom_range(1));
		pending_cmds.push_back(c);
	endtask

	task automatic push_query(logic [tis_pkg::POS_W-1:0] p);
		cmd_t c;
		c.op = tis_pkg::OP_QUERY;
		c.idx = tis_pkg::INDEX_W'($urandom);
		c.val = tis_pkg::VALUE_W'($urandom);
		c.pos = p;
		c.fin = 1'($urandom_range(1));
		pending_cmds.push_back(c);
	endtask

	task automatic drain();
		wait (pending_cmds.size() == 0 && !start && expected_samples.size() == 0);
		// writes leave no result; let the engine settle (wrap cubic worst case)
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(tis_pkg::cfg_index_t ix, logic [tis_pkg::CFG_DATA_W-1:0] d);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= ix;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (ix)
			tis_pkg::CFG_TABLE_LENGTH:  cur_len = d;
			tis_pkg::CFG_INTERPOLATION: cur_interp = d[0];
			default:                    cur_edge = d[0];
		endcase
	endtask

	task automatic setup(int len, logic interp, logic edg);
		logic [tis_pkg::CFG_DATA_W-1:0] junk;
		drain();
		junk = tis_pkg::CFG_DATA_W'($urandom);
		write_reg(tis_pkg::CFG_TABLE_LENGTH, len[tis_pkg::CFG_DATA_W-1:0]);
		write_reg(tis_pkg::CFG_INTERPOLATION, {junk[tis_pkg::CFG_DATA_W-1:1], interp});
		write_reg(tis_pkg::CFG_EDGE_MODE, {junk[tis_pkg::CFG_DATA_W-2:0], edg});
	endtask

	task automatic run_phase(int n);
		int len, r;
		longint span;
		len = (cur_len > DEPTH) ? DEPTH : int'(cur_len);
		span = longint'(len + 2) << FB;
		push_query(32'sd0);
		push_query(32'h7fff_ffff);
		push_query(32'h8000_0000);
		push_query(32'hffff_ffff);
		push_query(32'h0000_8000);
		push_query((len > 0) ? (len - 1) << FB : 0);
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < 15)
				push_write($urandom_range(DEPTH - 1),
					($urandom_range(3) == 0) ? (($urandom_range(1) != 0) ? 32767 : -32768)
					: int'($urandom));
			else if (r < 30)
				push_query($urandom);
			else
				push_query(32'($signed(longint'($urandom_range(32'(2 * span)))) - span));
		end
	endtask

	initial begin
		for (int i = 0; i < DEPTH; i++)
			shadow_table[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		// empty table after reset
		run_phase(10);
		// load every entry so no query ever reads an unwritten one
		for (int i = 0; i < DEPTH; i++)
			push_write(i, (i % 4 == 0) ? 32767 : (i % 4 == 2) ? -32768 : int'($urandom));
		push_write(1, -32768);
		push_write(2, 32767);
		push_write(3, -32768);
		setup(1, tis_pkg::INTERP_CUBIC, tis_pkg::EDGE_WRAP);
		run_phase(30);
		setup(1, tis_pkg::INTERP_CUBIC, tis_pkg::EDGE_CLAMP);
		run_phase(30);
		setup(2, tis_pkg::INTERP_CUBIC, tis_pkg::EDGE_WRAP);
		run_phase(40);
		no_gaps = 1'b1;
		setup(4, tis_pkg::INTERP_CUBIC, tis_pkg::EDGE_CLAMP);
		run_phase(100);
		drain();
		no_gaps = 1'b0;
		setup(1024, tis_pkg::INTERP_CUBIC, tis_pkg::EDGE_WRAP);
		run_phase(60);
		setup(2047, tis_pkg::INTERP_LINEAR, tis_pkg::EDGE_WRAP);
		run_phase(60);
		setup(1024, tis_pkg::INTERP_LINEAR, tis_pkg::EDGE_CLAMP);
		run_phase(60);
		setup(3, tis_pkg::INTERP_LINEAR, tis_pkg::EDGE_WRAP);
		run_phase(50);
		setup(0, tis_pkg::INTERP_CUBIC, tis_pkg::EDGE_WRAP);
		run_phase(10);
		for (int ph = 0; ph < 6; ph++) begin
			setup(($urandom_range(3) == 0) ? $urandom_range(2047) : $urandom_range(1, 12),
				1'($urandom_range(1)), 1'($urandom_range(1)));
			run_phase(40);
		end
		drain();
		if (mismatches == 0)
			$display("table_interpolating_sampler: match");
		else
			$display("table_interpolating_sampler: mismatch");
		$finish;
	end

endmodule
